[rtl/vkd_pkg.sv]
// Shared widths, character constants and key codes of the VT100 key decoder.
package vkd_pkg;

	localparam int ByteW  = 8;
	localparam int KeyW   = 9;
	localparam int CountW = 8;
	localparam int ProdW  = 12;

	localparam logic [ByteW-1:0] ChEsc   = 8'h1b;
	localparam logic [ByteW-1:0] ChLbr   = 8'h5b;
	localparam logic [ByteW-1:0] ChO     = 8'h4f;
	localparam logic [ByteW-1:0] ChTilde = 8'h7e;
	localparam logic [ByteW-1:0] ChZero  = 8'h30;
	localparam logic [ByteW-1:0] ChNine  = 8'h39;
	localparam logic [ByteW-1:0] ChLowF  = 8'h66;
	localparam logic [ByteW-1:0] ChLowB  = 8'h62;
	localparam logic [ByteW-1:0] ChLowD  = 8'h64;
	localparam logic [ByteW-1:0] ChUpA   = 8'h41;
	localparam logic [ByteW-1:0] ChUpB   = 8'h42;
	localparam logic [ByteW-1:0] ChUpC   = 8'h43;
	localparam logic [ByteW-1:0] ChUpD   = 8'h44;
	localparam logic [ByteW-1:0] ChUpF   = 8'h46;
	localparam logic [ByteW-1:0] ChUpH   = 8'h48;

	localparam logic [CountW-1:0] CountMax = 8'hff;

	localparam logic [KeyW-1:0] KeyUp     = 9'h100;
	localparam logic [KeyW-1:0] KeyDown   = 9'h101;
	localparam logic [KeyW-1:0] KeyRight  = 9'h102;
	localparam logic [KeyW-1:0] KeyLeft   = 9'h103;
	localparam logic [KeyW-1:0] KeyHome   = 9'h104;
	localparam logic [KeyW-1:0] KeyEnd    = 9'h105;
	localparam logic [KeyW-1:0] KeyDelete = 9'h106;
	localparam logic [KeyW-1:0] KeyNone   = 9'h107;
	localparam logic [KeyW-1:0] KeyWFwd   = 9'h108;
	localparam logic [KeyW-1:0] KeyWBack  = 9'h109;
	localparam logic [KeyW-1:0] KeyWDel   = 9'h10a;

endpackage

[rtl/vkd_byte_if.sv]
// Request channel that carries one received terminal byte.
interface vkd_byte_if;
	logic                       valid;
	logic                       ready;
	logic [vkd_pkg::ByteW-1:0]  rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

[rtl/vkd_key_if.sv]
// Request channel that carries one decoded key code.
interface vkd_key_if;
	logic                      valid;
	logic                      ready;
	logic [vkd_pkg::KeyW-1:0]  key_code;

	modport source(output valid, output key_code, input ready);
	modport sink(input valid, input key_code, output ready);
endinterface

[rtl/vt100_key_decoder_core.sv]
// VT100 key decoder: terminal bytes in, key codes out, one byte per cycle unless the key side stalls.
//
// The rx channel takes one terminal byte per request; the key channel gives
// one key code per request. A plain byte yields its own code, while the bytes
// of an escape sequence are absorbed until the sequence ends and then yield a
// single code, so some requests on rx produce no request on key.
// A byte is captured in an input register, decoded against the sequence
// state by short logic and written to the output register. One byte is
// taken every cycle while the output register can be emptied or refilled.
// Reset clears both registers and returns the decoder to the no-sequence
// state with the count at zero; no request is lost or repeated.
// When the key receiver stalls, the output register holds its code and the
// input register holds the next byte; rx.ready stays high until the input
// register is full, then follows key.ready.
module vt100_key_decoder_core (
	input logic       clk,
	input logic       arst_n,
	vkd_byte_if.sink  rx,
	vkd_key_if.source key
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ESC,
		PH_CSI,
		PH_COUNT
	} phase_t;

	phase_t                       phase_q;
	phase_t                       phase_d;
	logic [vkd_pkg::CountW-1:0]   count_q;
	logic [vkd_pkg::CountW-1:0]   count_d;
	logic                         valid_s1;
	logic [vkd_pkg::ByteW-1:0]    byte_s1;
	logic                         valid_s2;
	logic [vkd_pkg::KeyW-1:0]     code_s2;

	logic                         take_s1;
	logic                         emit;
	logic [vkd_pkg::KeyW-1:0]     key_d;
	logic                         is_digit;
	logic [vkd_pkg::ByteW-1:0]    digit_full;
	logic [vkd_pkg::ProdW-1:0]    prod;
	logic [vkd_pkg::KeyW-1:0]     meta_key;
	logic [vkd_pkg::KeyW-1:0]     csi_key;
	logic [vkd_pkg::KeyW-1:0]     count_key;

	assign take_s1   = valid_s1 && (!valid_s2 || key.ready);
	assign rx.ready  = !valid_s1 || take_s1;
	assign key.valid = valid_s2;
	assign key.key_code = code_s2;

	assign is_digit   = (byte_s1 >= vkd_pkg::ChZero) && (byte_s1 <= vkd_pkg::ChNine);
	assign digit_full = byte_s1 - vkd_pkg::ChZero;
	assign prod = ({{(vkd_pkg::ProdW - vkd_pkg::CountW){1'b0}}, count_q}
		* vkd_pkg::ProdW'(10))
		+ {{(vkd_pkg::ProdW - 4){1'b0}}, digit_full[3:0]};

	always_comb begin
		unique case (byte_s1)
			vkd_pkg::ChLowF: meta_key = vkd_pkg::KeyWFwd;
			vkd_pkg::ChLowB: meta_key = vkd_pkg::KeyWBack;
			vkd_pkg::ChLowD: meta_key = vkd_pkg::KeyWDel;
			default:         meta_key = vkd_pkg::KeyNone;
		endcase
	end

	always_comb begin
		unique case (byte_s1)
			vkd_pkg::ChUpA: csi_key = vkd_pkg::KeyUp;
			vkd_pkg::ChUpB: csi_key = vkd_pkg::KeyDown;
			vkd_pkg::ChUpC: csi_key = vkd_pkg::KeyRight;
			vkd_pkg::ChUpD: csi_key = vkd_pkg::KeyLeft;
			vkd_pkg::ChUpH: csi_key = vkd_pkg::KeyHome;
			vkd_pkg::ChUpF: csi_key = vkd_pkg::KeyEnd;
			default:        csi_key = vkd_pkg::KeyNone;
		endcase
	end

	always_comb begin
		unique case (count_q)
			8'd1, 8'd7: count_key = vkd_pkg::KeyHome;
			8'd3:       count_key = vkd_pkg::KeyDelete;
			8'd4, 8'd8: count_key = vkd_pkg::KeyEnd;
			default:    count_key = vkd_pkg::KeyNone;
		endcase
	end

	always_comb begin
		phase_d = PH_IDLE;
		count_d = count_q;
		emit    = 1'b1;
		key_d   = {1'b0, byte_s1};
		unique case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == vkd_pkg::ChEsc) begin
					phase_d = PH_ESC;
					emit    = 1'b0;
				end
			end
			PH_ESC: begin
				if (byte_s1 == vkd_pkg::ChLbr || byte_s1 == vkd_pkg::ChO) begin
					phase_d = PH_CSI;
					emit    = 1'b0;
				end else begin
					key_d = meta_key;
				end
			end
			PH_CSI: begin
				if (is_digit) begin
					phase_d = PH_COUNT;
					count_d = {{(vkd_pkg::CountW - 4){1'b0}}, digit_full[3:0]};
					emit    = 1'b0;
				end else begin
					key_d = csi_key;
				end
			end
			PH_COUNT: begin
				if (is_digit) begin
					phase_d = PH_COUNT;
					emit    = 1'b0;
					if (prod > {{(vkd_pkg::ProdW - vkd_pkg::CountW){1'b0}},
						vkd_pkg::CountMax}) begin
						count_d = vkd_pkg::CountMax;
					end else begin
						count_d = prod[vkd_pkg::CountW-1:0];
					end
				end else if (byte_s1 == vkd_pkg::ChTilde) begin
					key_d = count_key;
				end else begin
					key_d = vkd_pkg::KeyNone;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= '0;
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			valid_s2 <= 1'b0;
			code_s2  <= '0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
				byte_s1  <= rx.rx_byte;
			end
			if (take_s1) begin
				phase_q <= phase_d;
				count_q <= count_d;
			end
			if (take_s1 && emit) begin
				valid_s2 <= 1'b1;
				code_s2  <= key_d;
			end else if (key.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

endmodule

[sim/tb_vt100_key_decoder_core.sv]
// Self-checking testbench for vt100_key_decoder_core: byte stream in, key codes checked.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		SeqIdle,
		SeqEsc,
		SeqCsi,
		SeqCount
	} seq_phase_t;

	logic clk;
	logic arst_n;

	vkd_byte_if rx_if ();
	vkd_key_if  key_if ();

	vt100_key_decoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.key    (key_if)
	);

	seq_phase_t                   seq_phase;
	logic [vkd_pkg::CountW-1:0]   seq_count;
	logic [vkd_pkg::KeyW-1:0]     expected_keys[$];
	int                           mismatch_count;
	int                           bytes_sent;
	bit                           rx_idle;
	bit                           key_idle;
	bit                           hold_go;
	logic                         key_hold;

	localparam logic [vkd_pkg::ByteW-1:0] CsiLetters[6] = '{
		vkd_pkg::ChUpA, vkd_pkg::ChUpB, vkd_pkg::ChUpC,
		vkd_pkg::ChUpD, vkd_pkg::ChUpH, vkd_pkg::ChUpF};
	localparam logic [vkd_pkg::ByteW-1:0] MetaLetters[3] = '{
		vkd_pkg::ChLowF, vkd_pkg::ChLowB, vkd_pkg::ChLowD};
	localparam int                        KeyCounts[5] = '{1, 3, 4, 7, 8};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#500000;
		$display("vt100_key_decoder_core: mismatch");
		$finish;
	end

	function automatic logic [vkd_pkg::KeyW-1:0] count_to_key(
		input logic [vkd_pkg::CountW-1:0] n);
		case (n)
			8'd1, 8'd7: return vkd_pkg::KeyHome;
			8'd3:       return vkd_pkg::KeyDelete;
			8'd4, 8'd8: return vkd_pkg::KeyEnd;
			default:    return vkd_pkg::KeyNone;
		endcase
	endfunction

	// Advances the sequence state by one byte; returns 1 when a key code is produced.
	function automatic bit decode_byte(input logic [vkd_pkg::ByteW-1:0] b,
		output logic [vkd_pkg::KeyW-1:0] k);
		bit is_digit;
		int n;
		is_digit = (b >= vkd_pkg::ChZero) && (b <= vkd_pkg::ChNine);
		k = vkd_pkg::KeyNone;
		case (seq_phase)
			SeqIdle: begin
				if (b == vkd_pkg::ChEsc) begin
					seq_phase = SeqEsc;
					return 1'b0;
				end
				k = {1'b0, b};
			end
			SeqEsc: begin
				if (b == vkd_pkg::ChLbr || b == vkd_pkg::ChO) begin
					seq_phase = SeqCsi;
					return 1'b0;
				end
				case (b)
					vkd_pkg::ChLowF: k = vkd_pkg::KeyWFwd;
					vkd_pkg::ChLowB: k = vkd_pkg::KeyWBack;
					vkd_pkg::ChLowD: k = vkd_pkg::KeyWDel;
					default:         k = vkd_pkg::KeyNone;
				endcase
			end
			SeqCsi: begin
				if (is_digit) begin
					seq_count = b - vkd_pkg::ChZero;
					seq_phase = SeqCount;
					return 1'b0;
				end
				case (b)
					vkd_pkg::ChUpA: k = vkd_pkg::KeyUp;
					vkd_pkg::ChUpB: k = vkd_pkg::KeyDown;
					vkd_pkg::ChUpC: k = vkd_pkg::KeyRight;
					vkd_pkg::ChUpD: k = vkd_pkg::KeyLeft;
					vkd_pkg::ChUpH: k = vkd_pkg::KeyHome;
					vkd_pkg::ChUpF: k = vkd_pkg::KeyEnd;
					default:        k = vkd_pkg::KeyNone;
				endcase
			end
			default: begin
				if (is_digit) begin
					n = int'(seq_count) * 10 + int'(b - vkd_pkg::ChZero);
					seq_count = (n > 255) ? vkd_pkg::CountMax : vkd_pkg::CountW'(n);
					return 1'b0;
				end
				k = (b == vkd_pkg::ChTilde) ? count_to_key(seq_count) : vkd_pkg::KeyNone;
			end
		endcase
		seq_phase = SeqIdle;
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [vkd_pkg::ByteW-1:0] b);
		int gap;
		logic [vkd_pkg::KeyW-1:0] k;
		gap = rx_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		bytes_sent++;
		if (decode_byte(b, k)) begin
			expected_keys.push_back(k);
		end
	endtask

	task automatic send_count(input int value, input int zeros,
		input logic [vkd_pkg::ByteW-1:0] term);
		string digits;
		digits = $sformatf("%0d", value);
		repeat (zeros) send_byte(vkd_pkg::ChZero);
		for (int i = 0; i < digits.len(); i++) begin
			send_byte(vkd_pkg::ByteW'(digits[i]));
		end
		send_byte(term);
	endtask

	// Key receiver and checker.
	initial begin
		int stall;
		key_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = key_idle ? $urandom_range(0, 9) : 0;
			if (stall > 0 || key_hold) begin
				key_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (key_hold) @(posedge clk);
			end
			key_if.ready <= 1'b1;
			do @(posedge clk); while (!key_if.valid);
			if (expected_keys.size() == 0) begin
				$error("key_code: expected none, actual %0h", key_if.key_code);
				mismatch_count++;
			end else begin
				if (key_if.key_code !== expected_keys[0]) begin
					$error("key_code: expected %0h, actual %0h", expected_keys[0],
						key_if.key_code);
					mismatch_count++;
				end
				void'(expected_keys.pop_front());
			end
		end
	end

	// Long hold-off of the key receiver, counted here.
	initial begin
		key_hold <= 1'b0;
		forever begin
			wait (hold_go);
			hold_go = 1'b0;
			@(posedge clk);
			key_hold <= 1'b1;
			repeat (300) @(posedge clk);
			key_hold <= 1'b0;
		end
	end

	task automatic test_plain_bytes();
		send_byte(8'h00);
		send_byte(8'hff);
	endtask

	task automatic test_meta_keys();
		foreach (MetaLetters[i]) begin
			send_byte(vkd_pkg::ChEsc);
			send_byte(MetaLetters[i]);
		end
		send_byte(vkd_pkg::ChEsc);
		send_byte(vkd_pkg::ChEsc);
	endtask

	task automatic test_cursor_keys();
		send_byte(vkd_pkg::ChEsc);
		send_byte(vkd_pkg::ChLbr);
		send_byte(vkd_pkg::ChUpA);
		send_byte(vkd_pkg::ChEsc);
		send_byte(vkd_pkg::ChO);
		send_byte(vkd_pkg::ChUpH);
		send_byte(vkd_pkg::ChEsc);
		send_byte(vkd_pkg::ChLbr);
		send_byte(8'h5a);
	endtask

	task automatic test_counted_keys();
		send_byte(vkd_pkg::ChEsc);
		send_byte(vkd_pkg::ChLbr);
		send_count(3, 1, vkd_pkg::ChTilde);
		send_byte(vkd_pkg::ChEsc);
		send_byte(vkd_pkg::ChO);
		send_count(99999, 0, vkd_pkg::ChTilde);
		send_byte(vkd_pkg::ChEsc);
		send_byte(vkd_pkg::ChLbr);
		send_count(7, 0, 8'h71);
	endtask

	task automatic test_random_stream();
		int stop_at;
		int kind;
		logic [vkd_pkg::ByteW-1:0] intro;
		stop_at = bytes_sent + 240;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 15) == 0) begin
				rx_idle  = ($urandom_range(0, 3) != 0);
				key_idle = ($urandom_range(0, 3) != 0);
			end
			kind = $urandom_range(0, 9);
			intro = $urandom_range(0, 1) ? vkd_pkg::ChLbr : vkd_pkg::ChO;
			if ($urandom_range(0, 7) == 0) begin
				intro = vkd_pkg::ByteW'($urandom_range(0, 255));
			end
			case (kind)
				0, 1: send_byte(vkd_pkg::ByteW'($urandom_range(0, 255)));
				2: begin
					send_byte(vkd_pkg::ChEsc);
					if ($urandom_range(0, 3) == 0) begin
						send_byte(vkd_pkg::ByteW'($urandom_range(0, 255)));
					end else begin
						send_byte(MetaLetters[$urandom_range(0, 2)]);
					end
				end
				3, 4, 5: begin
					send_byte(vkd_pkg::ChEsc);
					send_byte(intro);
					if ($urandom_range(0, 3) == 0) begin
						send_byte(vkd_pkg::ByteW'($urandom_range(0, 255)));
					end else begin
						send_byte(CsiLetters[$urandom_range(0, 5)]);
					end
				end
				6, 7, 8: begin
					send_byte(vkd_pkg::ChEsc);
					send_byte(intro);
					send_count(
						$urandom_range(0, 1) ? KeyCounts[$urandom_range(0, 4)] :
						($urandom_range(0, 7) == 0) ? $urandom_range(256, 999999) :
						$urandom_range(0, 999),
						$urandom_range(0, 2),
						($urandom_range(0, 7) == 0) ?
							vkd_pkg::ByteW'($urandom_range(0, 255)) : vkd_pkg::ChTilde);
				end
				default: begin
					repeat ($urandom_range(1, 4))
						send_byte(vkd_pkg::ByteW'($urandom_range(0, 255)));
				end
			endcase
		end
	endtask

	task automatic test_output_stall();
		rx_idle  = 1'b0;
		key_idle = 1'b0;
		hold_go  = 1'b1;
		repeat (40) send_byte(vkd_pkg::ByteW'($urandom_range(0, 255)));
		send_byte(vkd_pkg::ChEsc);
		send_byte(vkd_pkg::ChLbr);
		send_count(4, 0, vkd_pkg::ChTilde);
		rx_idle  = 1'b1;
		key_idle = 1'b1;
	endtask

	initial begin
		seq_phase      = SeqIdle;
		seq_count      = '0;
		mismatch_count = 0;
		bytes_sent     = 0;
		rx_idle        = 1'b1;
		key_idle       = 1'b1;
		hold_go        = 1'b0;
		arst_n        <= 1'b0;
		rx_if.valid   <= 1'b0;
		rx_if.rx_byte <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_bytes();
		test_meta_keys();
		test_cursor_keys();
		test_counted_keys();
		test_random_stream();
		test_output_stall();
		test_random_stream();
		rx_if.valid <= 1'b0;
		while (expected_keys.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("vt100_key_decoder_core: match");
		end else begin
			$display("vt100_key_decoder_core: mismatch");
		end
		$finish;
	end

endmodule
